FILE: rtl/core/pigst_pkg.sv
package pigst_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int ID_W        = 11;
    localparam int TIME_W      = 32;
    localparam int RSLOT_W     = 6;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 216;
    localparam int KIND_W      = 2;

    localparam logic [TIME_W-1:0] NO_GAP = 32'hFFFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPD  = 2'd0,
        KIND_NEW  = 2'd1,
        KIND_DROP = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GAP,
        ST_WRITE,
        ST_RD_ISSUE,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [TIME_W-1:0] count;
        logic [TIME_W-1:0] first_ms;
        logic [TIME_W-1:0] last_ms;
        logic [TIME_W-1:0] min_gap;
        logic [TIME_W-1:0] max_gap;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic gap_en;
        logic wr_en;
        logic rd_issue;
        logic rd_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/pigst_ctrl.sv
module pigst_ctrl
    import pigst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tuser == OP_READ)
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                cmd.gap_en = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.rd_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/pigst_dp.sv
module pigst_dp
    import pigst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]      m_tuser
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    entry_t mem [SLOTS];
    entry_t rdata_reg;
    logic   mem_ren;
    logic   mem_wen;
    logic [SW-1:0] mem_raddr;
    entry_t mem_wdata;

    logic [ID_W-1:0]    id_reg, id_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [RSLOT_W-1:0] rd_reg, rd_next;

    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [TIME_W-1:0] total_reg, total_next;

    logic [SW-1:0] iss_idx_reg, iss_idx_next;
    logic          iss_act_reg, iss_act_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_reg, hit_next;
    logic [SW-1:0] hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic [SW-1:0] free_idx_reg, free_idx_next;
    entry_t        ent_reg, ent_next;

    entry_t            cur_reg, cur_next;
    logic [SW-1:0]     slot_idx_reg, slot_idx_next;
    kind_t             kind_reg, kind_next;
    logic [TIME_W-1:0] gap_reg, gap_next;
    logic              rdhit_reg, rdhit_next;

    logic                   out_vld_reg, out_vld_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic   match;
    entry_t fresh;
    entry_t cur_sel;
    entry_t upd;
    entry_t shown;
    logic [TIME_W-1:0] min_disp;
    logic [TIME_W-1:0] total_inc;
    logic [SW-1:0]     rd_idx;

    always_ff @(posedge clk)
    begin
        if (mem_wen)
        begin
            mem[slot_idx_reg] <= mem_wdata;
        end
        if (mem_ren)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            total_reg    <= '0;
            iss_act_reg  <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            total_reg    <= total_next;
            iss_act_reg  <= iss_act_next;
            cmp_vld_reg  <= cmp_vld_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        now_reg      <= now_next;
        rd_reg       <= rd_next;
        iss_idx_reg  <= iss_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        ent_reg      <= ent_next;
        cur_reg      <= cur_next;
        slot_idx_reg <= slot_idx_next;
        kind_reg     <= kind_next;
        gap_reg      <= gap_next;
        rdhit_reg    <= rdhit_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        rd_idx    = SW'(rd_reg);
        match     = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rdata_reg.frame_id == id_reg);
        total_inc = total_reg + 32'd1;

        fresh          = '0;
        fresh.frame_id = id_reg;
        fresh.min_gap  = NO_GAP;

        if (hit_reg)
        begin
            cur_sel = ent_reg;
        end
        else
        begin
            cur_sel = fresh;
        end

        upd         = cur_reg;
        upd.last_ms = now_reg;
        upd.count   = cur_reg.count + 32'd1;
        if (cur_reg.count == '0)
        begin
            upd.first_ms = now_reg;
        end
        else
        begin
            if (gap_reg < cur_reg.min_gap)
            begin
                upd.min_gap = gap_reg;
            end
            if (gap_reg > cur_reg.max_gap)
            begin
                upd.max_gap = gap_reg;
            end
        end
        mem_wdata = upd;

        if (cmd.rd_out)
        begin
            shown = rdata_reg;
        end
        else
        begin
            shown = upd;
        end
        min_disp = (shown.min_gap == NO_GAP) ? '0 : shown.min_gap;

        id_next       = id_reg;
        now_next      = now_reg;
        rd_next       = rd_reg;
        valid_next    = valid_reg;
        total_next    = total_reg;
        iss_idx_next  = iss_idx_reg;
        iss_act_next  = iss_act_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        ent_next      = ent_reg;
        cur_next      = cur_reg;
        slot_idx_next = slot_idx_reg;
        kind_next     = kind_reg;
        gap_next      = gap_reg;
        rdhit_next    = rdhit_reg;
        out_kind_next = out_kind_reg;
        out_data_next = out_data_reg;
        mem_ren       = 1'b0;
        mem_wen       = 1'b0;
        mem_raddr     = iss_idx_reg;

        if (cmd.load)
        begin
            id_next      = s_tdata[10:0];
            now_next     = s_tdata[42:11];
            rd_next      = s_tdata[48:43];
            iss_idx_next = '0;
            iss_act_next = 1'b1;
            cmp_vld_next = 1'b0;
            hit_next     = 1'b0;
            free_next    = 1'b0;
        end

        if (cmd.scan_en)
        begin
            cmp_vld_next = iss_act_reg;
            cmp_idx_next = iss_idx_reg;
            if (iss_act_reg)
            begin
                mem_ren = 1'b1;
                if (!valid_reg[iss_idx_reg] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = iss_idx_reg;
                end
                if (iss_idx_reg == LAST)
                begin
                    iss_act_next = 1'b0;
                end
                else
                begin
                    iss_idx_next = iss_idx_reg + 1'b1;
                end
            end
            if (match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
                ent_next     = rdata_reg;
            end
        end

        if (cmd.gap_en)
        begin
            cur_next = cur_sel;
            gap_next = now_reg - cur_sel.last_ms;
            priority if (hit_reg)
            begin
                slot_idx_next = hit_idx_reg;
                kind_next     = KIND_UPD;
            end
            else if (free_reg)
            begin
                slot_idx_next = free_idx_reg;
                kind_next     = KIND_NEW;
            end
            else
            begin
                slot_idx_next = '0;
                kind_next     = KIND_DROP;
            end
        end

        if (cmd.wr_en)
        begin
            out_kind_next = kind_reg;
            if (kind_reg == KIND_DROP)
            begin
                out_data_next = {6'b0, total_reg, 178'b0};
            end
            else
            begin
                mem_wen                  = 1'b1;
                valid_next[slot_idx_reg] = 1'b1;
                total_next               = total_inc;
                out_data_next = {6'b0, total_inc, shown.max_gap, min_disp, shown.last_ms,
                                 shown.first_ms, shown.count, shown.frame_id, 1'b1,
                                 6'(slot_idx_reg)};
            end
        end

        if (cmd.rd_issue)
        begin
            mem_ren    = 1'b1;
            mem_raddr  = rd_idx;
            rdhit_next = (32'(rd_reg) < 32'(SLOTS)) && valid_reg[rd_idx];
        end

        if (cmd.rd_out)
        begin
            out_kind_next = KIND_READ;
            if (rdhit_reg)
            begin
                out_data_next = {6'b0, total_reg, shown.max_gap, min_disp, shown.last_ms,
                                 shown.first_ms, shown.count, shown.frame_id, 1'b1, rd_reg};
            end
            else
            begin
                out_data_next = {6'b0, total_reg, 172'b0, rd_reg};
            end
        end

        if (cmd.wr_en || cmd.rd_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end

        status.scan_done = cmp_vld_reg && (match || (cmp_idx_reg == LAST));
        status.out_free  = !out_vld_reg || m_tready;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

FILE: rtl/core/per_id_frame_gap_stats_table.sv
// Record word: scan of the slot table at one slot a cycle, then gap and write;
// the scan ends at a matching slot or at the last slot, and the write waits for a free output.
// Read word: the slot is read from memory, then the result is registered.
// Throughput: one word at a time, the next accepted once the result word is registered.
// Reset (rst_n low, asynchronous): slot valid bits, frame total and control cleared;
// slot memory is not cleared, unused slots are masked by their valid bits.
module per_id_frame_gap_stats_table
    import pigst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // frame_id, now_ms, read_slot, zero pad
    input  logic                   s_tuser,  // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // slot, slot_in_use, slot_frame_id, slot_count,
                                             // slot_first_ms, slot_last_ms, slot_min_gap,
                                             // slot_max_gap, all_frames, zero pad
    output logic [KIND_W-1:0]      m_tuser   // result_kind
);

    cmd_t    cmd;
    status_t status;

    pigst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pigst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/core/pigst_chk.sv
module pigst_chk
    import pigst_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]      m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DROP) |-> (m_tdata[177:0] == '0))
        else $error("dropped record shows slot contents");

    a_unused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_READ) && !m_tdata[6] |-> (m_tdata[177:7] == '0))
        else $error("read of unused slot shows contents");

    a_record_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == KIND_UPD) || (m_tuser == KIND_NEW)) |-> m_tdata[6])
        else $error("recorded slot not marked in use");

    a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NEW) |->
            (m_tdata[49:18] == 32'd1) && (m_tdata[177:114] == '0) &&
            (m_tdata[81:50] == m_tdata[113:82]))
        else $error("new slot statistics wrong");

endmodule

bind per_id_frame_gap_stats_table pigst_chk u_pigst_chk (.*);
